[rtl/slseq_pkg.sv]
// Shared types, constants and codes for the status LED sequencer.
`default_nettype none

package slseq_pkg;

   // Event kinds carried on the request tuser field.
   typedef enum logic [1:0] {
      MODE_POWER  = 2'd0,
      MODE_LINK   = 2'd1,
      MODE_BUTTON = 2'd2,
      MODE_TICK   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      PW_CHARGING    = 2'd0,
      PW_CHARGED     = 2'd1,
      PW_DISCHARGING = 2'd2,
      PW_CRITICAL    = 2'd3
   } power_type;

   typedef enum logic [1:0] {
      LK_UNPAIRED  = 2'd0,
      LK_PAIRING   = 2'd1,
      LK_CONNECTED = 2'd2
   } link_type;

   // Link codes as they arrive on the request word.
   localparam logic [1:0] LINK_IN_DISCONNECTED = 2'd0;
   localparam logic [1:0] LINK_IN_PAIRING      = 2'd1;
   localparam logic [1:0] LINK_IN_CONNECTED    = 2'd2;

   // Configuration register indexes.
   localparam logic [1:0] CSR_BLUETOOTH_ENABLED  = 2'd0;
   localparam logic [1:0] CSR_HEARTBEAT_DISABLED = 2'd1;
   localparam logic [1:0] CSR_HW_BLINKS_CHARGING = 2'd2;

   localparam logic [31:0] CRITICAL_PERIOD_MS = 32'd30000;
   localparam logic [31:0] FAST_BLINK_MS      = 32'd2000;
   localparam logic [31:0] PAIRING_WINDOW_MS  = 32'd30000;
   localparam logic [31:0] BUTTON_SHOW_MS     = 32'd10000;

   localparam logic [9:0] INTERVAL_IDLE_MS  = 10'd1000;
   localparam logic [9:0] INTERVAL_FAST_MS  = 10'd250;
   localparam logic [9:0] INTERVAL_OFF_MS   = 10'd999;
   localparam logic [9:0] INTERVAL_FLASH_MS = 10'd1;

   localparam logic [6:0] PCT_FULL     = 7'd100;
   localparam logic [6:0] PCT_CRITICAL = 7'd5;
   localparam logic [6:0] PCT_GAUGE_1  = 7'd25;
   localparam logic [6:0] PCT_GAUGE_2  = 7'd50;
   localparam logic [6:0] PCT_GAUGE_3  = 7'd75;

   typedef struct packed {
      logic bluetooth_enabled;
      logic heartbeat_disabled;
      logic hw_blinks_charging;
   } cfg_type;

   typedef struct packed {
      power_type   power_mode;
      link_type    link_mode;
      logic [31:0] pairing_start_ms;
      logic [31:0] critical_start_ms;
      logic [31:0] button_time_ms;
      logic        fast_blink_active;
      logic        power_led_level;
      logic        pairing_led_level;
      logic        slow_phase;
      logic [6:0]  latched_percent;
   } state_type;

   typedef struct packed {
      logic [9:0] interval_ms;
      logic [2:0] battery_leds_lit;
      logic       pairing_led;
      logic       power_led;
   } result_type;

endpackage

`default_nettype wire

[rtl/slseq_core.sv]
// Event decode and LED pattern logic: next state and result for one event word.
`default_nettype none

module slseq_core (
   input  wire slseq_pkg::mode_type   mode,
   input  wire logic [31:0]           now_ms,
   input  wire logic                  has_usb,
   input  wire logic                  is_charging,
   input  wire logic [6:0]            battery_percent,
   input  wire logic [1:0]            link_state,
   input  wire slseq_pkg::cfg_type    cfg,
   input  wire slseq_pkg::state_type  cur,
   output slseq_pkg::state_type       nxt,
   output slseq_pkg::result_type      res,
   output logic                       has_result
);

   logic [31:0] crit_end;
   logic [31:0] fast_end;
   logic [31:0] pair_end;
   logic [31:0] button_end;
   logic [9:0]  interval;
   logic [2:0]  lit;

   always_comb begin
      nxt        = cur;
      interval   = slseq_pkg::INTERVAL_IDLE_MS;
      lit        = 3'd0;
      has_result = 1'b0;
      crit_end   = cur.critical_start_ms + slseq_pkg::CRITICAL_PERIOD_MS;
      fast_end   = 32'd0;
      pair_end   = cur.pairing_start_ms + slseq_pkg::PAIRING_WINDOW_MS;
      button_end = cur.button_time_ms + slseq_pkg::BUTTON_SHOW_MS;

      unique case (mode)
         slseq_pkg::MODE_POWER: begin
            nxt.latched_percent = battery_percent;
            if (has_usb || is_charging) begin
               nxt.power_mode = (battery_percent >= slseq_pkg::PCT_FULL) ?
                                slseq_pkg::PW_CHARGED : slseq_pkg::PW_CHARGING;
            end else begin
               nxt.power_mode = (battery_percent > slseq_pkg::PCT_CRITICAL) ?
                                slseq_pkg::PW_DISCHARGING : slseq_pkg::PW_CRITICAL;
            end
         end
         slseq_pkg::MODE_LINK: begin
            unique case (link_state)
               slseq_pkg::LINK_IN_DISCONNECTED: begin
                  nxt.link_mode        = slseq_pkg::LK_UNPAIRED;
                  nxt.pairing_start_ms = now_ms;
               end
               slseq_pkg::LINK_IN_PAIRING: begin
                  nxt.link_mode        = slseq_pkg::LK_PAIRING;
                  nxt.pairing_start_ms = now_ms;
               end
               slseq_pkg::LINK_IN_CONNECTED: begin
                  // Already connected: the pairing window keeps its start.
                  if (cur.link_mode != slseq_pkg::LK_CONNECTED) begin
                     nxt.link_mode        = slseq_pkg::LK_CONNECTED;
                     nxt.pairing_start_ms = now_ms;
                  end
               end
               default: begin
                  // Unknown link code leaves the link state alone.
               end
            endcase
         end
         slseq_pkg::MODE_BUTTON: begin
            nxt.button_time_ms = now_ms;
         end
         slseq_pkg::MODE_TICK: begin
            has_result = 1'b1;
            unique case (cur.power_mode)
               slseq_pkg::PW_CHARGING: begin
                  if (!cfg.hw_blinks_charging) begin
                     nxt.power_led_level = !cur.power_led_level;
                  end
               end
               slseq_pkg::PW_CHARGED: begin
                  nxt.power_led_level = 1'b1;
               end
               slseq_pkg::PW_CRITICAL: begin
                  // Every 30 s a 2 s burst of fast blinking.
                  if ((crit_end < now_ms) && !cur.fast_blink_active) begin
                     nxt.fast_blink_active = 1'b1;
                     nxt.critical_start_ms = now_ms;
                  end
                  fast_end = nxt.critical_start_ms + slseq_pkg::FAST_BLINK_MS;
                  if (nxt.fast_blink_active) begin
                     nxt.pairing_led_level = 1'b0;
                     nxt.power_led_level   = !nxt.power_led_level;
                     interval              = slseq_pkg::INTERVAL_FAST_MS;
                     if (fast_end < now_ms) begin
                        nxt.fast_blink_active = 1'b0;
                        nxt.power_led_level   = 1'b0;
                     end
                  end
               end
               default: begin
               end
            endcase

            // Heartbeat: a short flash once a second.
            if (cur.power_mode != slseq_pkg::PW_CHARGING &&
                cur.power_mode != slseq_pkg::PW_CHARGED && !nxt.fast_blink_active) begin
               if (nxt.power_led_level) begin
                  nxt.power_led_level = 1'b0;
                  interval            = slseq_pkg::INTERVAL_OFF_MS;
               end else begin
                  nxt.power_led_level = 1'b1;
                  interval            = slseq_pkg::INTERVAL_FLASH_MS;
               end
            end

            priority if (!cfg.bluetooth_enabled || (pair_end < now_ms) ||
                         nxt.fast_blink_active) begin
               nxt.pairing_led_level = 1'b0;
            end else if (cur.link_mode == slseq_pkg::LK_UNPAIRED) begin
               if (cur.slow_phase) begin
                  nxt.pairing_led_level = !nxt.pairing_led_level;
                  nxt.slow_phase        = 1'b0;
               end else begin
                  nxt.slow_phase = 1'b1;
               end
            end else if (cur.link_mode == slseq_pkg::LK_PAIRING) begin
               nxt.pairing_led_level = !nxt.pairing_led_level;
            end else begin
               nxt.pairing_led_level = 1'b1;
            end

            if (cfg.heartbeat_disabled) begin
               nxt.power_led_level = 1'b0;
            end

            if ((button_end > now_ms) || nxt.power_led_level) begin
               lit = 3'd1
                   + {2'd0, (cur.latched_percent >= slseq_pkg::PCT_GAUGE_1)}
                   + {2'd0, (cur.latched_percent >= slseq_pkg::PCT_GAUGE_2)}
                   + {2'd0, (cur.latched_percent >= slseq_pkg::PCT_GAUGE_3)};
            end
         end
         default: begin
         end
      endcase

      res.power_led        = nxt.power_led_level;
      res.pairing_led      = nxt.pairing_led_level;
      res.battery_leds_lit = lit;
      res.interval_ms      = interval;
   end

endmodule

`default_nettype wire

[rtl/status_led_sequencer.sv]
// Top level of the status LED sequencer: input stage, state, result register and CSRs.
`default_nettype none

// The sequencer takes one event word per cycle and keeps up with a new word on
// every clock while no tick is held back by a full result register. A word is
// captured in the input stage register; in the following cycle, unless a tick
// is held, the event logic applies it to the sequencer state and, for a scheduler
// tick, loads the result register, from which the tick's result is offered.
// Power, link and button events change the state only and produce no result
// word. The single input stage and the result register are what set the pace:
// the input stage only holds a tick while the result register is full and not
// being taken, so a stalled result side backs up the request side after one
// more tick word. Configuration writes take effect on the edge at which csr_we
// is high and should only be made while the block is idle.

module status_led_sequencer (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [31:0] now_ms, [32] has_usb, [33] is_charging, [40:34] battery_percent,
   // [42:41] link_state, [47:43] zero
   input  wire logic [47:0] req_tdata,
   // [1:0] mode
   input  wire logic [1:0]  req_tuser,

   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [0] power_led, [1] pairing_led, [4:2] battery_leds_lit, [14:5] interval_ms,
   // [15] zero
   output logic [15:0]      rsp_tdata,

   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_addr,
   input  wire logic        csr_wdata
);

   // Input stage.
   logic                  stg_valid_ff, stg_valid_in;
   slseq_pkg::mode_type   stg_mode_ff;
   logic [42:0]           stg_data_ff;

   // Sequencer state and configuration.
   slseq_pkg::state_type  state_ff, state_in;
   slseq_pkg::cfg_type    cfg_ff, cfg_in;

   // Result register.
   logic                  rsp_valid_ff, rsp_valid_in;
   slseq_pkg::result_type rsp_data_ff;

   slseq_pkg::result_type core_res;
   logic                  core_has_result;
   logic                  out_free;
   logic                  stg_go;
   logic                  req_take;

   // The result register can take a new word if it is empty or being emptied.
   assign out_free = !rsp_valid_ff || rsp_tready;
   // A non-tick event never waits; a tick waits for room in the result register.
   assign stg_go   = stg_valid_ff && (!core_has_result || out_free);
   assign req_tready = !stg_valid_ff || stg_go;
   assign req_take   = req_tvalid && req_tready;

   slseq_core u_core (
      .mode            (stg_mode_ff),
      .now_ms          (stg_data_ff[31:0]),
      .has_usb         (stg_data_ff[32]),
      .is_charging     (stg_data_ff[33]),
      .battery_percent (stg_data_ff[40:34]),
      .link_state      (stg_data_ff[42:41]),
      .cfg             (cfg_ff),
      .cur             (state_ff),
      .nxt             (state_in),
      .res             (core_res),
      .has_result      (core_has_result)
   );

   always_comb begin
      stg_valid_in = stg_valid_ff;
      if (req_take) begin
         stg_valid_in = 1'b1;
      end else if (stg_go) begin
         stg_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (stg_go && core_has_result) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            slseq_pkg::CSR_BLUETOOTH_ENABLED:  cfg_in.bluetooth_enabled  = csr_wdata;
            slseq_pkg::CSR_HEARTBEAT_DISABLED: cfg_in.heartbeat_disabled = csr_wdata;
            slseq_pkg::CSR_HW_BLINKS_CHARGING: cfg_in.hw_blinks_charging = csr_wdata;
            default: begin
               // Writes past the last register are dropped.
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cfg_ff.bluetooth_enabled  <= 1'b1;
         cfg_ff.heartbeat_disabled <= 1'b0;
         cfg_ff.hw_blinks_charging <= 1'b0;
         state_ff.power_mode        <= slseq_pkg::PW_DISCHARGING;
         state_ff.link_mode         <= slseq_pkg::LK_UNPAIRED;
         state_ff.pairing_start_ms  <= 32'd0;
         state_ff.critical_start_ms <= 32'd0;
         state_ff.button_time_ms    <= 32'd0;
         state_ff.fast_blink_active <= 1'b0;
         state_ff.power_led_level   <= 1'b0;
         state_ff.pairing_led_level <= 1'b0;
         state_ff.slow_phase        <= 1'b0;
         state_ff.latched_percent   <= 7'd0;
      end else begin
         stg_valid_ff <= stg_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
         if (stg_go) begin
            state_ff <= state_in;
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_take) begin
         stg_mode_ff <= slseq_pkg::mode_type'(req_tuser);
         stg_data_ff <= req_tdata[42:0];
      end
      if (stg_go && core_has_result) begin
         rsp_data_ff <= core_res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_data_ff};

endmodule

`default_nettype wire

[tb/status_led_sequencer_checker.sv]
// Checker for the status LED sequencer: mirrors the sequencer state and compares every result word.
module status_led_sequencer_checker
   import slseq_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [47:0] req_tdata,
   input  wire logic [1:0]  req_tuser,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [15:0] rsp_tdata,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_addr,
   input  wire logic        csr_wdata,
   output int               pending,
   output int               errors
);
   timeunit 1ns;
   timeprecision 1ps;

   cfg_type     cfg;
   power_type   pwr;
   link_type    lnk;
   logic [31:0] pair_start_ms;
   logic [31:0] crit_start_ms;
   logic [31:0] button_ms;
   logic        fast_on;
   logic        power_lvl;
   logic        pair_lvl;
   logic        slow_ph;
   logic [6:0]  pct_held;
   result_type  led_results_q[$];
   result_type  got;
   result_type  want;

   // Deadline test on the wrapping millisecond counter: the sum is cut to 32 bits first.
   function automatic logic is_past(input logic [31:0] base, input logic [31:0] span,
                                    input logic [31:0] now_ms);
      logic [31:0] deadline;
      deadline = base + span;
      return deadline < now_ms;
   endfunction

   task automatic note_mismatch(input string what, input int exp_val, input int act_val);
      errors++;
      if (errors <= 10) begin
         $display("%t: %s mismatch, expected %0d, got %0d", $realtime, what, exp_val, act_val);
      end
   endtask

   task automatic clear_state();
      cfg           = '{bluetooth_enabled: 1'b1, heartbeat_disabled: 1'b0,
                        hw_blinks_charging: 1'b0};
      pwr           = PW_DISCHARGING;
      lnk           = LK_UNPAIRED;
      pair_start_ms = '0;
      crit_start_ms = '0;
      button_ms     = '0;
      fast_on       = 1'b0;
      power_lvl     = 1'b0;
      pair_lvl      = 1'b0;
      slow_ph       = 1'b0;
      pct_held      = '0;
   endtask

   // Applies one accepted event word; a scheduler tick queues the LED word it should produce.
   task automatic apply_event(input mode_type kind, input logic [47:0] word);
      logic [31:0] now_ms;
      logic        usb;
      logic        chg;
      logic [6:0]  pct;
      logic [1:0]  link_in;
      logic [31:0] show_until;
      result_type  r;
      now_ms  = word[31:0];
      usb     = word[32];
      chg     = word[33];
      pct     = word[40:34];
      link_in = word[42:41];
      case (kind)
         MODE_POWER: begin
            pct_held = pct;
            if (usb || chg) begin
               pwr = (pct >= PCT_FULL) ? PW_CHARGED : PW_CHARGING;
            end else begin
               pwr = (pct > PCT_CRITICAL) ? PW_DISCHARGING : PW_CRITICAL;
            end
         end
         MODE_LINK: begin
            case (link_in)
               LINK_IN_DISCONNECTED: begin
                  lnk           = LK_UNPAIRED;
                  pair_start_ms = now_ms;
               end
               LINK_IN_PAIRING: begin
                  lnk           = LK_PAIRING;
                  pair_start_ms = now_ms;
               end
               LINK_IN_CONNECTED: begin
                  if (lnk != LK_CONNECTED) begin
                     lnk           = LK_CONNECTED;
                     pair_start_ms = now_ms;
                  end
               end
               default: ;
            endcase
         end
         MODE_BUTTON: begin
            button_ms = now_ms;
         end
         default: begin
            r.interval_ms = INTERVAL_IDLE_MS;
            case (pwr)
               PW_CHARGING: begin
                  if (!cfg.hw_blinks_charging) power_lvl = ~power_lvl;
               end
               PW_CHARGED: begin
                  power_lvl = 1'b1;
               end
               PW_CRITICAL: begin
                  if (is_past(crit_start_ms, CRITICAL_PERIOD_MS, now_ms) && !fast_on) begin
                     fast_on       = 1'b1;
                     crit_start_ms = now_ms;
                  end
                  if (fast_on) begin
                     pair_lvl      = 1'b0;
                     power_lvl     = ~power_lvl;
                     r.interval_ms = INTERVAL_FAST_MS;
                     if (is_past(crit_start_ms, FAST_BLINK_MS, now_ms)) begin
                        fast_on   = 1'b0;
                        power_lvl = 1'b0;
                     end
                  end
               end
               default: ;
            endcase

            // Heartbeat: a short flash followed by a long dark gap.
            if (pwr != PW_CHARGING && pwr != PW_CHARGED && !fast_on) begin
               if (power_lvl) begin
                  power_lvl     = 1'b0;
                  r.interval_ms = INTERVAL_OFF_MS;
               end else begin
                  power_lvl     = 1'b1;
                  r.interval_ms = INTERVAL_FLASH_MS;
               end
            end

            if (!cfg.bluetooth_enabled || fast_on
                || is_past(pair_start_ms, PAIRING_WINDOW_MS, now_ms)) begin
               pair_lvl = 1'b0;
            end else if (lnk == LK_UNPAIRED) begin
               if (slow_ph) begin
                  pair_lvl = ~pair_lvl;
                  slow_ph  = 1'b0;
               end else begin
                  slow_ph = 1'b1;
               end
            end else if (lnk == LK_PAIRING) begin
               pair_lvl = ~pair_lvl;
            end else begin
               pair_lvl = 1'b1;
            end

            if (cfg.heartbeat_disabled) power_lvl = 1'b0;

            // The gauge shows for a while after a button press, or while the LED is lit.
            show_until         = button_ms + BUTTON_SHOW_MS;
            r.battery_leds_lit = 3'd0;
            if (show_until > now_ms || power_lvl) begin
               r.battery_leds_lit = 3'd1;
               if (pct_held >= PCT_GAUGE_1) r.battery_leds_lit = r.battery_leds_lit + 3'd1;
               if (pct_held >= PCT_GAUGE_2) r.battery_leds_lit = r.battery_leds_lit + 3'd1;
               if (pct_held >= PCT_GAUGE_3) r.battery_leds_lit = r.battery_leds_lit + 3'd1;
            end
            r.power_led   = power_lvl;
            r.pairing_led = pair_lvl;
            led_results_q.push_back(r);
         end
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_state();
         led_results_q.delete();
         errors = 0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_BLUETOOTH_ENABLED:  cfg.bluetooth_enabled  = csr_wdata;
               CSR_HEARTBEAT_DISABLED: cfg.heartbeat_disabled = csr_wdata;
               CSR_HW_BLINKS_CHARGING: cfg.hw_blinks_charging = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got = result_type'(rsp_tdata[14:0]);
            if (led_results_q.size() == 0) begin
               note_mismatch("unrequested result word", 0, rsp_tdata);
            end else begin
               want = led_results_q.pop_front();
               if (got.power_led !== want.power_led)
                  note_mismatch("power_led", want.power_led, got.power_led);
               if (got.pairing_led !== want.pairing_led)
                  note_mismatch("pairing_led", want.pairing_led, got.pairing_led);
               if (got.battery_leds_lit !== want.battery_leds_lit)
                  note_mismatch("battery_leds_lit", want.battery_leds_lit, got.battery_leds_lit);
               if (got.interval_ms !== want.interval_ms)
                  note_mismatch("interval_ms", want.interval_ms, got.interval_ms);
            end
         end
         if (req_tvalid && req_tready) apply_event(mode_type'(req_tuser), req_tdata);
      end
      pending = led_results_q.size();
   end

endmodule

[tb/tb_status_led_sequencer.sv]
// Testbench top for the status LED sequencer: clock, reset, event stimulus, idling and verdict.
module tb_status_led_sequencer;
   timeunit 1ns;
   timeprecision 1ps;

   import slseq_pkg::*;

   // The link field has a fourth code that the block must ignore.
   localparam logic [1:0] LINK_IN_UNKNOWN = 2'd3;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;
   logic        csr_we;
   logic [1:0]  csr_addr;
   logic        csr_wdata;
   int          pending;
   int          errors;

   // Idling control. A burst starts with a chance of one in gap_odds (sender) or
   // stall_odds (receiver) per opportunity; calm switches all idling off for the
   // final stretch of the run.
   bit          calm;
   int          gap_odds;
   int          stall_odds;

   // Running millisecond time handed to the block. It is free to wrap.
   logic [31:0] stamp;

   // Register settings per random phase, as {bluetooth_enabled, heartbeat_disabled,
   // hw_blinks_charging}. All-off and all-on are both there, and every bit changes.
   logic [2:0]  cfg_plan [6] = '{3'b000, 3'b111, 3'b101, 3'b010, 3'b110, 3'b100};
   int          phase;

   status_led_sequencer dut (.*);

   status_led_sequencer_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop well beyond the slowest correct run, with the longest gaps and
   // stalls on every word.
   initial begin
      #5_000_000;
      $display("tb_status_led_sequencer: done, errors");
      $finish;
   end

   // The result side. Each pass makes one assignment to rsp_tready and then moves
   // on by at least one edge, so a stall burst never collides with a release.
   initial begin
      rsp_tready <= 1'b0;
      @(posedge clock);
      forever begin
         if (!calm && stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Offers one event word and returns at the edge that takes it. The ready line is
   // looked at on the falling edge, when everything driven at the rising edge has
   // settled, so the decision never hangs on scheduling order.
   task automatic send_word(input mode_type kind, input logic [31:0] at_ms, input logic usb,
                            input logic chg, input logic [6:0] pct, input logic [1:0] link_in);
      logic took;
      if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {5'd0, link_in, pct, chg, usb, at_ms};
      do begin
         @(negedge clock);
         took = req_tready;
         @(posedge clock);
      end while (!took);
   endtask

   // A tick ignores everything but the time, so the other fields carry noise.
   task automatic tick(input logic [31:0] at_ms);
      send_word(MODE_TICK, at_ms, 1'($urandom), 1'($urandom), 7'($urandom), 2'($urandom));
   endtask

   task automatic power_word(input logic [31:0] at_ms, input logic usb, input logic chg,
                             input logic [6:0] pct);
      send_word(MODE_POWER, at_ms, usb, chg, pct, 2'($urandom));
   endtask

   task automatic link_word(input logic [31:0] at_ms, input logic [1:0] link_in);
      send_word(MODE_LINK, at_ms, 1'($urandom), 1'($urandom), 7'($urandom), link_in);
   endtask

   // Lets every expected result come out, then waits out the input stage so that
   // a power, link or button word still in flight has landed in the state as well.
   task automatic settle();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] index, input logic value);
      csr_we    <= 1'b1;
      csr_addr  <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly ticks, with power, link and button events mixed in. Time usually moves
   // by the fast-blink step or about a heartbeat, now and then far enough to open a
   // critical period or close the pairing window, and rarely jumps anywhere at all.
   task automatic random_run(input int count);
      int          n;
      int          pick;
      mode_type    kind;
      logic [6:0]  pct;
      logic [1:0]  link_in;
      for (n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 60)      kind = MODE_TICK;
         else if (pick < 75) kind = MODE_POWER;
         else if (pick < 90) kind = MODE_LINK;
         else                kind = MODE_BUTTON;

         case ($urandom_range(0, 7))
            0, 1, 2: stamp = stamp + INTERVAL_FAST_MS;
            3, 4:    stamp = stamp + $urandom_range(1, 1000);
            5:       stamp = stamp + $urandom_range(0, 3000);
            6:       stamp = stamp + $urandom_range(0, 60000);
            default: begin
               if ($urandom_range(0, 3) == 0) stamp = $urandom();
               else                           stamp = stamp + INTERVAL_IDLE_MS;
            end
         endcase

         // Low values reach the critical state, values above 100 are legal too.
         case ($urandom_range(0, 5))
            0:       pct = 7'($urandom_range(0, PCT_CRITICAL + 1));
            1:       pct = 7'($urandom_range(PCT_FULL + 1, 127));
            default: pct = 7'($urandom_range(0, PCT_FULL));
         endcase
         link_in = ($urandom_range(0, 9) == 0) ? LINK_IN_UNKNOWN : 2'($urandom_range(0, 2));

         send_word(kind, stamp, 1'($urandom), 1'($urandom), pct, link_in);
      end
   endtask

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= MODE_POWER;
      csr_we     <= 1'b0;
      csr_addr   <= CSR_BLUETOOTH_ENABLED;
      csr_wdata  <= 1'b0;
      calm       = 1'b0;
      gap_odds   = 4;
      stall_odds = 4;
      stamp      = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part, with the register values left at their reset settings.
      // From reset the block is discharging, so the first ticks give the heartbeat.
      tick(32'd0);
      tick(32'd1);
      // A percentage above 100 on USB power counts as charged and fills the gauge.
      power_word(32'd10, 1'b1, 1'b0, 7'd127);
      tick(32'd20);
      // Exactly 100 while charging is charged; one less is still charging.
      power_word(32'd30, 1'b0, 1'b1, PCT_FULL);
      power_word(32'd40, 1'b0, 1'b1, 7'd99);
      tick(32'd50);
      tick(32'd60);
      // Pairing, then connected twice: the repeat must not restart the window.
      link_word(32'd70, LINK_IN_PAIRING);
      tick(32'd80);
      link_word(32'd100, LINK_IN_CONNECTED);
      link_word(32'd20000, LINK_IN_CONNECTED);
      // An unknown link code changes nothing.
      link_word(32'd20010, LINK_IN_UNKNOWN);
      tick(32'd31000);
      // Five percent off the charger is critical; past 30 s the fast blink starts
      // and runs for 2 s.
      power_word(32'd31010, 1'b0, 1'b0, PCT_CRITICAL);
      tick(32'd40000);
      tick(32'd40250);
      tick(32'd42100);
      send_word(MODE_BUTTON, 32'd42200, 1'b1, 1'b1, 7'd0, LINK_IN_PAIRING);
      tick(32'd42300);
      link_word(32'd42400, LINK_IN_DISCONNECTED);
      // Empty battery off the charger, then the top of the time range.
      power_word(32'd42500, 1'b0, 1'b0, 7'd0);
      tick(32'd42600);
      power_word(32'hFFFF_FF00, 1'b0, 1'b0, 7'd6);
      tick(32'hFFFF_FFFF);

      // Random phases, one register setting each. The third phase starts just short
      // of the counter wrap so that the windows straddle it; the last runs with no
      // idling on either side.
      stamp = 32'd50000;
      for (phase = 0; phase < 6; phase++) begin
         settle();
         write_reg(CSR_BLUETOOTH_ENABLED, cfg_plan[phase][2]);
         write_reg(CSR_HEARTBEAT_DISABLED, cfg_plan[phase][1]);
         write_reg(CSR_HW_BLINKS_CHARGING, cfg_plan[phase][0]);
         gap_odds   = $urandom_range(0, 1) ? $urandom_range(2, 12) : 0;
         stall_odds = $urandom_range(0, 1) ? $urandom_range(2, 12) : 0;
         if (phase == 2) stamp = 32'hFFFE_0000;
         if (phase == 5) calm = 1'b1;
         random_run(300);
      end

      settle();
      if (errors == 0) begin
         $display("tb_status_led_sequencer: done, clean");
      end else begin
         $display("tb_status_led_sequencer: done, errors");
      end
      $finish;
   end

endmodule
